### sv/wed_pkg.sv
package wed_pkg;

   localparam int unsigned MAX_LEN_DEF = 4096;
   localparam int unsigned SYM_W       = 8;
   localparam int unsigned COST_W      = 22;
   localparam int unsigned CFG_W       = 8;
   localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFF;

   // register indexes on the csr port
   localparam logic [1:0] REG_INSERT  = 2'd0;
   localparam logic [1:0] REG_DELETE  = 2'd1;
   localparam logic [1:0] REG_REPLACE = 2'd2;
   localparam logic [1:0] REG_SWAP    = 2'd3;

   // which_string codes
   localparam logic STR_SOURCE = 1'b0;
   localparam logic STR_TARGET = 1'b1;

   typedef struct packed {
      logic busy;
      logic rsp_pending;
   } back_status_type;

endpackage

### sv/wed_queue.sv
module wed_queue #(
   parameter int unsigned WIDTH = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] slot_ff [2];
   logic [WIDTH-1:0] slot_in [2];
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      if (pop && count_ff != 2'd0) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_ff - 2'd1;
      end
      if (push && count_in != 2'd2) begin
         slot_in[count_in[0]] = push_data;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[0];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != 2'd2)
      else $error("job queue overflow");

endmodule

### sv/wed_front.sv
module wed_front #(
   parameter int unsigned MAX_LEN = wed_pkg::MAX_LEN_DEF,
   parameter int unsigned LW      = $clog2(MAX_LEN + 1),
   parameter int unsigned IW      = $clog2(MAX_LEN)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_which_string,
   input  logic [wed_pkg::SYM_W-1:0]     req_symbol,
   input  logic                          req_last_symbol,
   input  wed_pkg::back_status_type      status,
   input  logic                          queue_not_empty,
   output logic                          src_we,
   output logic                          tgt_we,
   output logic [IW-1:0]                 wr_addr,
   output logic [wed_pkg::SYM_W-1:0]     wr_data,
   output logic                          job_push,
   output logic [2*LW-1:0]               job_data
);

   logic [LW-1:0] src_len_ff, src_len_in;
   logic [LW-1:0] tgt_len_ff, tgt_len_in;
   logic          accept;
   logic          src_room, tgt_room;

   assign req_ready = !status.busy && !queue_not_empty;
   assign accept    = req_valid && req_ready;
   assign src_room  = (src_len_ff != LW'(MAX_LEN));
   assign tgt_room  = (tgt_len_ff != LW'(MAX_LEN));

   assign src_we   = accept && req_which_string == wed_pkg::STR_SOURCE && src_room;
   assign tgt_we   = accept && req_which_string == wed_pkg::STR_TARGET && tgt_room;
   assign wr_addr  = (req_which_string == wed_pkg::STR_SOURCE) ?
                     src_len_ff[IW-1:0] : tgt_len_ff[IW-1:0];
   assign wr_data  = req_symbol;
   assign job_push = accept && req_which_string == wed_pkg::STR_TARGET && req_last_symbol;
   assign job_data = {src_len_ff, tgt_len_ff + LW'(tgt_room)};

   always_comb begin
      src_len_in = src_len_ff;
      tgt_len_in = tgt_len_ff;
      if (src_we) begin
         src_len_in = src_len_ff + LW'(1);
      end
      if (tgt_we) begin
         tgt_len_in = tgt_len_ff + LW'(1);
      end
      if (job_push) begin
         src_len_in = '0;
         tgt_len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_len_ff <= '0;
         tgt_len_ff <= '0;
      end else begin
         src_len_ff <= src_len_in;
         tgt_len_ff <= tgt_len_in;
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      src_len_ff <= LW'(MAX_LEN) && tgt_len_ff <= LW'(MAX_LEN))
      else $error("string length beyond limit");

endmodule

### sv/wed_back.sv
module wed_back #(
   parameter int unsigned MAX_LEN = wed_pkg::MAX_LEN_DEF,
   parameter int unsigned LW      = $clog2(MAX_LEN + 1),
   parameter int unsigned IW      = $clog2(MAX_LEN),
   parameter int unsigned CW      = $clog2(MAX_LEN) + 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wed_pkg::CFG_W-1:0]     ins_cost,
   input  logic [wed_pkg::CFG_W-1:0]     del_cost,
   input  logic [wed_pkg::CFG_W-1:0]     rep_cost,
   input  logic [wed_pkg::CFG_W-1:0]     swp_cost,
   input  logic                          src_we,
   input  logic                          tgt_we,
   input  logic [IW-1:0]                 wr_addr,
   input  logic [wed_pkg::SYM_W-1:0]     wr_data,
   input  logic                          job_valid,
   input  logic [2*LW-1:0]               job_data,
   output logic                          job_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wed_pkg::COST_W-1:0]    rsp_total_cost,
   output wed_pkg::back_status_type      status
);

   localparam int unsigned SW = CW + wed_pkg::COST_W;

   logic [wed_pkg::SYM_W-1:0] src_mem [MAX_LEN];
   logic [wed_pkg::SYM_W-1:0] tgt_mem [MAX_LEN];
   logic [2*CW-1:0]           row_mem [MAX_LEN+1];

   logic [wed_pkg::SYM_W-1:0] src_q, tgt_q;
   logic [2*CW-1:0]           row_q;

   logic [LW-1:0] n_ff, m_ff, ai_ff, aj_ff, bi_ff, bj_ff;
   logic [LW-1:0] ai_m1, aj_m1;
   logic          a_act_ff, b_act_ff;
   logic [CW-1:0] upl_ff, up2l_ff, curl_ff, swl_ff, rowacc_ff;
   logic [wed_pkg::SYM_W-1:0] aprev_ff;
   logic          rsp_valid_ff;
   logic [wed_pkg::COST_W-1:0] cost_ff;

   logic [CW-1:0] ti, td, tr, ts, up, up2, cur, sw, dswap;
   logic [wed_pkg::CFG_W:0] ins_del;
   logic          start, eq, can_swap, row_end, done;
   logic [SW-1:0] cur_wide;

   function automatic logic [CW-1:0] lesser(input logic [CW-1:0] x, input logic [CW-1:0] y);
      return (x < y) ? x : y;
   endfunction

   // effective costs
   assign ins_del = {1'b0, ins_cost} + {1'b0, del_cost};
   assign ti = CW'(ins_cost);
   assign td = CW'(del_cost);
   assign ts = CW'(swp_cost);
   assign tr = ({1'b0, rep_cost} < ins_del) ? CW'(rep_cost) : CW'(ins_del);

   assign start   = job_valid && !a_act_ff && !b_act_ff && !rsp_valid_ff;
   assign job_pop = start;
   assign ai_m1   = ai_ff - LW'(1);
   assign aj_m1   = aj_ff - LW'(1);

   // symbol stores and row store, registered reads
   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[wr_addr] <= wr_data;
      end
      if (tgt_we) begin
         tgt_mem[wr_addr] <= wr_data;
      end
      src_q <= src_mem[ai_m1[IW-1:0]];
      tgt_q <= tgt_mem[aj_m1[IW-1:0]];
      row_q <= row_mem[aj_ff];
      if (b_act_ff) begin
         row_mem[bj_ff] <= {cur, up};
      end
   end

   // cell evaluation
   assign up       = row_q[2*CW-1:CW];
   assign up2      = row_q[CW-1:0];
   assign eq       = (src_q == tgt_q);
   assign can_swap = (bi_ff > LW'(1));
   assign row_end  = (bj_ff == m_ff);
   assign done     = b_act_ff && row_end && (bi_ff == n_ff);
   assign dswap    = swl_ff + ts + ((aprev_ff != tgt_q) ? tr : '0);

   always_comb begin
      cur = rowacc_ff;
      sw  = rowacc_ff;
      if (bj_ff != '0) begin
         if (bi_ff == '0) begin
            cur = curl_ff + ti;
            sw  = swl_ff;
         end else begin
            cur = lesser(up + td, curl_ff + ti);
            cur = lesser(cur, upl_ff + tr);
            if (eq) begin
               cur = lesser(cur, upl_ff);
            end
            sw = swl_ff;
            if (can_swap) begin
               cur = lesser(cur, dswap);
               sw  = lesser(eq ? up2l_ff : up2l_ff + tr, swl_ff + ti);
            end
         end
      end
   end

   assign cur_wide = SW'(cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_act_ff     <= 1'b0;
         b_act_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_act_ff <= a_act_ff;
         if (start) begin
            a_act_ff <= 1'b1;
         end else if (a_act_ff && aj_ff == m_ff && ai_ff == n_ff) begin
            a_act_ff <= 1'b0;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bi_ff <= ai_ff;
      bj_ff <= aj_ff;
      if (start) begin
         n_ff      <= job_data[2*LW-1:LW];
         m_ff      <= job_data[LW-1:0];
         ai_ff     <= '0;
         aj_ff     <= '0;
         rowacc_ff <= '0;
      end else if (a_act_ff) begin
         if (aj_ff == m_ff) begin
            aj_ff <= '0;
            ai_ff <= ai_ff + LW'(1);
         end else begin
            aj_ff <= aj_ff + LW'(1);
         end
      end
      if (b_act_ff) begin
         upl_ff  <= up;
         up2l_ff <= up2;
         curl_ff <= cur;
         swl_ff  <= sw;
         if (bj_ff == '0) begin
            rowacc_ff <= rowacc_ff + td;
         end
         if (row_end) begin
            aprev_ff <= src_q;
         end
      end
      if (done) begin
         cost_ff <= (cur_wide > SW'(wed_pkg::COST_MAX)) ?
                    wed_pkg::COST_MAX : cur_wide[wed_pkg::COST_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_cost     = cost_ff;
   assign status.busy        = a_act_ff || b_act_ff;
   assign status.rsp_pending = rsp_valid_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_valid_ff)
      else $error("result produced over a pending one");

   a_stage_follow: assert property (@(posedge clock) disable iff (reset)
      a_act_ff |=> b_act_ff)
      else $error("cell stage lost a column");

endmodule

### sv/weighted_edit_distance_with_swap.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_which_string, req_symbol, req_last_symbol
// rsp       out        rsp_valid / rsp_ready  rsp_total_cost
// csr       in         psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// symbols load into the source and target stores one item a cycle while req_ready is high
// the final target item queues a job; the sweep then walks the cost table row by row,
// one cell a cycle, paced by the single row store read/write port
// req_ready stays low while a job is queued or sweeping; symbols of the next pair load
// while the previous result still waits on rsp_ready
// synchronous active-high reset clears lengths, control and csr to their defaults
module weighted_edit_distance_with_swap #(
   parameter int unsigned MAX_LEN = wed_pkg::MAX_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_which_string,
   input  logic [wed_pkg::SYM_W-1:0]     req_symbol,
   input  logic                          req_last_symbol,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wed_pkg::COST_W-1:0]    rsp_total_cost,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int unsigned LW = $clog2(MAX_LEN + 1);
   localparam int unsigned IW = $clog2(MAX_LEN);

   // cost registers
   logic [wed_pkg::CFG_W-1:0] ins_ff, del_ff, rep_ff, swp_ff;
   logic                      csr_write;

   // front to back
   wed_pkg::back_status_type  status;
   logic                      src_we, tgt_we;
   logic [IW-1:0]             wr_addr;
   logic [wed_pkg::SYM_W-1:0] wr_data;
   logic                      job_push, job_pop, job_valid;
   logic [2*LW-1:0]           job_in, job_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff <= wed_pkg::CFG_W'(1);
         del_ff <= wed_pkg::CFG_W'(1);
         rep_ff <= wed_pkg::CFG_W'(1);
         swp_ff <= wed_pkg::CFG_W'(1);
      end else if (csr_write) begin
         case (paddr[3:2])
            wed_pkg::REG_INSERT:  ins_ff <= pwdata[wed_pkg::CFG_W-1:0];
            wed_pkg::REG_DELETE:  del_ff <= pwdata[wed_pkg::CFG_W-1:0];
            wed_pkg::REG_REPLACE: rep_ff <= pwdata[wed_pkg::CFG_W-1:0];
            wed_pkg::REG_SWAP:    swp_ff <= pwdata[wed_pkg::CFG_W-1:0];
            default:              ins_ff <= ins_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (paddr[3:2])
         wed_pkg::REG_INSERT:  prdata = 32'(ins_ff);
         wed_pkg::REG_DELETE:  prdata = 32'(del_ff);
         wed_pkg::REG_REPLACE: prdata = 32'(rep_ff);
         wed_pkg::REG_SWAP:    prdata = 32'(swp_ff);
         default:              prdata = '0;
      endcase
   end

   // front: takes items, fills the symbol stores, counts lengths
   wed_front #(.MAX_LEN(MAX_LEN), .LW(LW), .IW(IW)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_which_string (req_which_string),
      .req_symbol       (req_symbol),
      .req_last_symbol  (req_last_symbol),
      .status           (status),
      .queue_not_empty  (job_valid),
      .src_we           (src_we),
      .tgt_we           (tgt_we),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .job_push         (job_push),
      .job_data         (job_in)
   );

   // short job queue of string lengths
   wed_queue #(.WIDTH(2*LW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .not_empty (job_valid),
      .head      (job_head)
   );

   // back: row-by-row sweep of the cost table
   wed_back #(.MAX_LEN(MAX_LEN), .LW(LW), .IW(IW)) u_back (
      .clock          (clock),
      .reset          (reset),
      .ins_cost       (ins_ff),
      .del_cost       (del_ff),
      .rep_cost       (rep_ff),
      .swp_cost       (swp_ff),
      .src_we         (src_we),
      .tgt_we         (tgt_we),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .job_valid      (job_valid),
      .job_data       (job_head),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_total_cost (rsp_total_cost),
      .status         (status)
   );

   a_no_load_in_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !status.busy)
      else $error("item taken during sweep");

endmodule

### tb/tb_weighted_edit_distance_with_swap.sv
module tb_weighted_edit_distance_with_swap;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAXL      = wed_pkg::MAX_LEN_DEF;
   localparam int unsigned LIMIT     = 3_000_000;
   localparam int unsigned RAND_ITEMS = 1200;

   // directed row kinds: a plain item or a change of the cost registers first
   typedef enum logic [1:0] {
      CFG_KEEP, CFG_ZERO, CFG_FULL, CFG_CLAMP
   } cfg_sel_type;

   typedef struct {
      cfg_sel_type                 cfg;
      logic                        which;
      logic [wed_pkg::SYM_W-1:0]   sym;
      logic                        last;
      int unsigned                 reps;     // item repeated this many times
      bit                          typed;    // expected cost given in the row
      logic [wed_pkg::COST_W-1:0]  cost;
   } stim_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_which_string = 1'b0;
   logic [wed_pkg::SYM_W-1:0]   req_symbol = '0;
   logic                        req_last_symbol = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [wed_pkg::COST_W-1:0]  rsp_total_cost;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [3:0]                  paddr = '0;
   logic [31:0]                 pwdata = '0;
   logic [31:0]                 prdata;
   logic                        pready;

   // predictor state: its own copy of the strings and the cost registers
   logic [wed_pkg::SYM_W-1:0]   src_text [MAXL];
   logic [wed_pkg::SYM_W-1:0]   tgt_text [MAXL];
   int unsigned                 src_len = 0;
   int unsigned                 tgt_len = 0;
   int unsigned                 ins_c = 1, del_c = 1, rep_c = 1, swp_c = 1;
   int unsigned                 row_cost [3][MAXL+1];
   int unsigned                 swap_cost_row [MAXL+1];

   logic [wed_pkg::COST_W-1:0]  cost_queue [$];
   int unsigned                 mismatches = 0;
   int unsigned                 cycles = 0;
   bit                          req_fire = 1'b0;   // item taken at the coming edge
   bit                          calm = 1'b0;        // no idling in the closing stretch
   int unsigned                 rsp_hold = 0;

   weighted_edit_distance_with_swap i_dut (.*);

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= $urandom_range(0, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // sample mid-cycle, where nothing moves, for what the next edge takes
   always @(negedge clock) begin
      req_fire = req_valid && req_ready && !reset;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cost_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item, cost %0d", rsp_total_cost);
         end else begin
            logic [wed_pkg::COST_W-1:0] want;
            want = cost_queue.pop_front();
            if (rsp_total_cost !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("total_cost expected %0d got %0d", want, rsp_total_cost);
            end
         end
      end
   end

   function automatic int unsigned lesser(int unsigned a, int unsigned b);
      return (a < b) ? a : b;
   endfunction

   // row-by-row table with the extra swap row; arithmetic wraps at 32 bits
   function automatic logic [wed_pkg::COST_W-1:0] min_edit_cost();
      int unsigned n, m, tr, d, s, cur, up, up2;
      logic [wed_pkg::SYM_W-1:0] a, a_prev, b;
      bit can_swap;
      n  = src_len;
      m  = tgt_len;
      tr = lesser(rep_c, ins_c + del_c);
      for (int unsigned j = 0; j <= m; j++)
         row_cost[0][j] = ins_c * j;
      for (int unsigned i = 1; i <= n; i++) begin
         cur = i % 3;
         up  = (i - 1) % 3;
         up2 = (i + 1) % 3;
         can_swap = (i >= 2);
         a      = src_text[i-1];
         a_prev = can_swap ? src_text[i-2] : '0;
         row_cost[cur][0] = del_c * i;
         if (can_swap)
            swap_cost_row[0] = del_c * i;
         for (int unsigned j = 1; j <= m; j++) begin
            b = tgt_text[j-1];
            d = row_cost[up][j] + del_c;
            d = lesser(d, row_cost[cur][j-1] + ins_c);
            d = lesser(d, row_cost[up][j-1] + tr);
            if (a == b)
               d = lesser(d, row_cost[up][j-1]);
            if (can_swap) begin
               d = lesser(d, swap_cost_row[j-1] + swp_c + ((a_prev != b) ? tr : 0));
               s = row_cost[up2][j-1] + tr;
               if (a == b)
                  s = lesser(s, row_cost[up2][j-1]);
               s = lesser(s, swap_cost_row[j-1] + ins_c);
               swap_cost_row[j] = s;
            end
            row_cost[cur][j] = d;
         end
      end
      d = row_cost[n % 3][m];
      return (d > wed_pkg::COST_MAX) ? wed_pkg::COST_MAX : d[wed_pkg::COST_W-1:0];
   endfunction

   // one register write over the csr port: setup then access
   task automatic csr_write(logic [1:0] idx, logic [wed_pkg::CFG_W-1:0] val);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'h0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         wed_pkg::REG_INSERT:  ins_c = 32'(val);
         wed_pkg::REG_DELETE:  del_c = 32'(val);
         wed_pkg::REG_REPLACE: rep_c = 32'(val);
         default:              swp_c = 32'(val);
      endcase
   endtask

   // wait for the block to drain before touching the registers
   task automatic set_costs(logic [wed_pkg::CFG_W-1:0] ci, cd, cr, cs);
      req_valid <= 1'b0;
      wait (cost_queue.size() == 0);
      repeat (8) @(posedge clock);
      csr_write(wed_pkg::REG_INSERT, ci);
      csr_write(wed_pkg::REG_DELETE, cd);
      csr_write(wed_pkg::REG_REPLACE, cr);
      csr_write(wed_pkg::REG_SWAP, cs);
   endtask

   // drive one item, hold it until taken, then update the predicted strings
   task automatic send_item(logic w, logic [wed_pkg::SYM_W-1:0] s, logic l,
                            bit typed = 0, logic [wed_pkg::COST_W-1:0] typed_cost = '0);
      logic [wed_pkg::COST_W-1:0] c;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_which_string <= w;
      req_symbol       <= s;
      req_last_symbol  <= l;
      do @(posedge clock); while (!req_fire);
      if (w == wed_pkg::STR_SOURCE) begin
         if (src_len < MAXL) begin
            src_text[src_len] = s;
            src_len++;
         end
      end else begin
         if (tgt_len < MAXL) begin
            tgt_text[tgt_len] = s;
            tgt_len++;
         end
         if (l) begin
            c = min_edit_cost();
            cost_queue = {cost_queue, typed ? typed_cost : c};
            src_len = 0;
            tgt_len = 0;
         end
      end
   endtask

   function automatic logic [wed_pkg::SYM_W-1:0] pick_symbol();
      // a small alphabet most of the time so matches and swaps turn up
      if ($urandom_range(0, 9) < 7)
         return wed_pkg::SYM_W'(8'h61 + $urandom_range(0, 3));
      return wed_pkg::SYM_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [wed_pkg::CFG_W-1:0] pick_cost();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return wed_pkg::CFG_W'($urandom_range(0, 255));
      endcase
   endfunction

   stim_row_type plan [$];

   initial begin
      int unsigned sent;
      int unsigned n, m;

      // at reset every cost is one
      plan = '{
         // source last mark is ignored: still one string "a" against "a"
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'h61, 1'b1, 1, 1, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h61, 1'b1, 1, 1, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'h61, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h62, 1'b1, 1, 1, 22'd1},
         // empty source: inserts only
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h00, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'hFF, 1'b1, 1, 1, 22'd2},
         // plain adjacent swap of the byte extremes
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'hFF, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'h00, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h00, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'hFF, 1'b1, 1, 1, 22'd1},
         // swap with an insert between the swapped symbols
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'h61, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'h62, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h62, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h78, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h61, 1'b1, 1, 0, 22'd0},
         // source symbol arriving after target symbols
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h63, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'h64, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h64, 1'b1, 1, 0, 22'd0},
         // swap with no target left, under zero costs then full costs
         '{CFG_ZERO,  wed_pkg::STR_SOURCE, 8'h31, 1'b0, 3, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h32, 1'b1, 1, 1, 22'd0},
         '{CFG_FULL,  wed_pkg::STR_SOURCE, 8'h31, 1'b0, 3, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h31, 1'b1, 1, 1, 22'd510},
         // replace clamped to insert plus delete
         '{CFG_CLAMP, wed_pkg::STR_SOURCE, 8'h41, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h42, 1'b1, 1, 1, 22'd7},
         // over-long source, then over-long target: extra symbols dropped
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'h55, 1'b0, MAXL + 4, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h55, 1'b1, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_SOURCE, 8'h11, 1'b0, 1, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h22, 1'b0, MAXL + 4, 0, 22'd0},
         '{CFG_KEEP,  wed_pkg::STR_TARGET, 8'h11, 1'b1, 1, 0, 22'd0}
      };

      // single reset at the start
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         case (plan[k].cfg)
            CFG_ZERO:  set_costs(8'd0, 8'd0, 8'd0, 8'd0);
            CFG_FULL:  set_costs(8'd255, 8'd255, 8'd255, 8'd255);
            CFG_CLAMP: set_costs(8'd3, 8'd4, 8'd255, 8'd1);
            default: ;
         endcase
         for (int unsigned r = 0; r < plan[k].reps; r++)
            send_item(plan[k].which, plan[k].sym, plan[k].last,
                      plan[k].typed, plan[k].cost);
      end

      // random pairs of strings, new costs every few pairs
      sent = 0;
      while (sent < RAND_ITEMS) begin
         if ($urandom_range(0, 3) == 0)
            set_costs(pick_cost(), pick_cost(), pick_cost(), pick_cost());
         if (sent > RAND_ITEMS - 150)
            calm = 1'b1;
         case ($urandom_range(0, 9))
            0:       n = 0;
            1:       n = 12;
            default: n = $urandom_range(1, 8);
         endcase
         m = ($urandom_range(0, 9) == 0) ? 12 : $urandom_range(1, 8);
         for (int unsigned i = 0; i < n; i++) begin
            send_item(wed_pkg::STR_SOURCE, pick_symbol(), 1'($urandom_range(0, 1)));
            sent++;
         end
         for (int unsigned j = 0; j < m; j++) begin
            // now and then a source symbol slips in among the target ones
            if (j > 0 && $urandom_range(0, 19) == 0) begin
               send_item(wed_pkg::STR_SOURCE, pick_symbol(), 1'($urandom_range(0, 1)));
               sent++;
            end
            send_item(wed_pkg::STR_TARGET, pick_symbol(), j == m - 1);
            sent++;
         end
      end
      req_valid <= 1'b0;

      wait (cost_queue.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && cost_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
